/* src/quad9_shape_function_eval_defines.svh */
// Assertion macros shared by the shape function evaluator.
`ifndef QUAD9_SHAPE_FUNCTION_EVAL_DEFINES_SVH
`define QUAD9_SHAPE_FUNCTION_EVAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSF_ASSERT(lbl, clk, rst_n, prop, msg)
`define QSF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/qsf_pkg.sv */
`timescale 1ns / 1ps

package qsf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = FRAC_BITS + 3;

    // Operand a +/- 1.0 must hold both the input range and the scale.
    localparam int OP_W   = ((IN_W > FRAC_BITS + 2) ? IN_W : FRAC_BITS + 2) + 1;
    localparam int DER_W  = OP_W + 1;
    localparam int VAL_W  = 2 * OP_W;
    localparam int MAG_W  = VAL_W - 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int Q_W    = PROD_W + 1;

    localparam int SH_VAL = 3 * FRAC_BITS + 2;
    localparam int SH_DER = 2 * FRAC_BITS + 2;
    localparam int SH_W   = $clog2(SH_VAL + 1);

    localparam logic [3:0] NODE_MAX = 4'd8;

    localparam logic signed [OP_W-1:0]  S_ONE     = OP_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] S_SQ      = VAL_W'(1) << (2 * FRAC_BITS);
    localparam logic [Q_W-1:0]          SAT_LIMIT = Q_W'(1) << (FRAC_BITS + 1);

    typedef enum logic [1:0] {
        ACT_VALUE   = 2'd0,
        ACT_DXI     = 2'd1,
        ACT_DETA    = 2'd2,
        ACT_INVALID = 2'd3
    } t_action;

    typedef struct packed {
        logic            valid;
        logic            bad;
        logic            neg;
        logic [SH_W-1:0] sh;
    } t_ctrl;

    typedef struct packed {
        logic signed [OP_W-1:0]  a;
        logic signed [OP_W-1:0]  b;
        logic signed [DER_W-1:0] d;
        logic                    center;
        logic                    der;
    } t_axis;

endpackage

/* src/qsf_decode.sv */
`timescale 1ns / 1ps

module qsf_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [1:0]                      i_action,
    input  logic [3:0]                      i_node,
    input  logic signed [qsf_pkg::IN_W-1:0] i_xi,
    input  logic signed [qsf_pkg::IN_W-1:0] i_eta,
    output qsf_pkg::t_ctrl                  o_ctrl,
    output qsf_pkg::t_axis                  o_ax,
    output qsf_pkg::t_axis                  o_ay
);
    import qsf_pkg::*;

    typedef enum logic [1:0] {
        KIND_MINUS  = 2'd0,
        KIND_PLUS   = 2'd1,
        KIND_CENTER = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kx;
        t_kind      ky;
        logic [1:0] exp2;
        logic       neg;
    } t_node_desc;

    function automatic t_node_desc node_lookup(input logic [3:0] node);
        t_node_desc nd;
        unique case (node)
            4'd0:    nd = '{KIND_MINUS,  KIND_MINUS,  2'd0, 1'b0};
            4'd1:    nd = '{KIND_CENTER, KIND_MINUS,  2'd1, 1'b1};
            4'd2:    nd = '{KIND_PLUS,   KIND_MINUS,  2'd0, 1'b0};
            4'd3:    nd = '{KIND_PLUS,   KIND_CENTER, 2'd1, 1'b1};
            4'd4:    nd = '{KIND_PLUS,   KIND_PLUS,   2'd0, 1'b0};
            4'd5:    nd = '{KIND_CENTER, KIND_PLUS,   2'd1, 1'b1};
            4'd6:    nd = '{KIND_MINUS,  KIND_PLUS,   2'd0, 1'b0};
            4'd7:    nd = '{KIND_MINUS,  KIND_CENTER, 2'd1, 1'b1};
            4'd8:    nd = '{KIND_CENTER, KIND_CENTER, 2'd2, 1'b0};
            default: nd = '{KIND_CENTER, KIND_CENTER, 2'd0, 1'b0};
        endcase
        return nd;
    endfunction

    // Prepares the two multiplicands of x(x-1), x(x+1) or x*x - 1, and the
    // derivative factor 2x-1, 2x+1 or 2x, all at the input scale.
    function automatic t_axis make_axis(input t_kind kind,
                                        input logic signed [IN_W-1:0] coord,
                                        input logic der);
        t_axis                   ax;
        logic signed [OP_W-1:0]  a;
        logic signed [DER_W-1:0] twice;
        logic signed [DER_W-1:0] one;
        a     = OP_W'(coord);
        twice = {a, 1'b0};
        one   = DER_W'(S_ONE);
        ax.a      = a;
        ax.center = (kind == KIND_CENTER);
        ax.der    = der;
        case (kind)
            KIND_MINUS: begin
                ax.b = a - S_ONE;
                ax.d = twice - one;
            end
            KIND_PLUS: begin
                ax.b = a + S_ONE;
                ax.d = twice + one;
            end
            default: begin
                ax.b = a;
                ax.d = twice;
            end
        endcase
        return ax;
    endfunction

    t_node_desc      desc;
    t_action         act;
    logic            n_bad;
    logic [SH_W-1:0] n_sh;
    t_axis           n_ax;
    t_axis           n_ay;

    logic            r_valid;
    logic            r_bad;
    logic            r_neg;
    logic [SH_W-1:0] r_sh;
    t_axis           r_ax;
    t_axis           r_ay;

    always_comb begin
        desc  = node_lookup(i_node);
        act   = t_action'(i_action);
        n_bad = (act == ACT_INVALID) || (i_node > NODE_MAX);
        n_sh  = ((act == ACT_VALUE) ? SH_W'(SH_VAL) : SH_W'(SH_DER)) - SH_W'(desc.exp2);
        n_ax  = make_axis(desc.kx, i_xi, act == ACT_DXI);
        n_ay  = make_axis(desc.ky, i_eta, act == ACT_DETA);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad <= n_bad;
        r_neg <= desc.neg;
        r_sh  <= n_sh;
        r_ax  <= n_ax;
        r_ay  <= n_ay;
    end

    assign o_ctrl = '{valid: r_valid, bad: r_bad, neg: r_neg, sh: r_sh};
    assign o_ax   = r_ax;
    assign o_ay   = r_ay;

endmodule

/* src/qsf_factor.sv */
`timescale 1ns / 1ps

module qsf_factor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qsf_pkg::t_ctrl              i_ctrl,
    input  qsf_pkg::t_axis              i_ax,
    input  qsf_pkg::t_axis              i_ay,
    output qsf_pkg::t_ctrl              o_ctrl,
    output logic [qsf_pkg::MAG_W-1:0]   o_mx,
    output logic [qsf_pkg::MAG_W-1:0]   o_my
);
    import qsf_pkg::*;

    function automatic logic signed [VAL_W-1:0] axis_factor(input t_axis ax);
        logic signed [VAL_W-1:0] prod;
        logic signed [VAL_W-1:0] f;
        prod = ax.a * ax.b;
        if (ax.der) begin
            f = VAL_W'(ax.d);
        end else if (ax.center) begin
            f = prod - S_SQ;
        end else begin
            f = prod;
        end
        return f;
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] m;
        m = v[VAL_W-1] ? -v : v;
        return m[MAG_W-1:0];
    endfunction

    // Multiply stage.
    logic                    r_valid2;
    t_ctrl                   r_ctrl2;
    logic signed [VAL_W-1:0] r_fx;
    logic signed [VAL_W-1:0] r_fy;

    // Magnitude stage.
    logic                    r_valid3;
    t_ctrl                   r_ctrl3;
    logic [MAG_W-1:0]        r_mx;
    logic [MAG_W-1:0]        r_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid2 <= i_ctrl.valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl2 <= i_ctrl;
        r_fx    <= axis_factor(i_ax);
        r_fy    <= axis_factor(i_ay);
        // Each negative factor flips the sign carried alongside the magnitudes.
        r_ctrl3 <= '{valid: r_ctrl2.valid,
                     bad:   r_ctrl2.bad,
                     neg:   r_ctrl2.neg ^ r_fx[VAL_W-1] ^ r_fy[VAL_W-1],
                     sh:    r_ctrl2.sh};
        r_mx    <= magnitude(r_fx);
        r_my    <= magnitude(r_fy);
    end

    assign o_ctrl = '{valid: r_valid3, bad: r_ctrl3.bad, neg: r_ctrl3.neg, sh: r_ctrl3.sh};
    assign o_mx   = r_mx;
    assign o_my   = r_my;

endmodule

/* src/qsf_round.sv */
`timescale 1ns / 1ps

module qsf_round (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qsf_pkg::t_ctrl                    i_ctrl,
    input  logic [qsf_pkg::MAG_W-1:0]         i_mx,
    input  logic [qsf_pkg::MAG_W-1:0]         i_my,
    output logic                              o_done,
    output logic signed [qsf_pkg::OUT_W-1:0]  o_result_value,
    output logic                              o_bad_index
);
    import qsf_pkg::*;

    logic [Q_W-1:0]          rnd;
    logic [Q_W-1:0]          biased;
    logic                    sat;
    logic [Q_W-1:0]          clipped;
    logic signed [OUT_W-1:0] mag_out;
    logic signed [OUT_W-1:0] n_result;

    // Product stage.
    logic                    r_valid4;
    t_ctrl                   r_ctrl4;
    logic [PROD_W-1:0]       r_prod;

    // Round and shift stage.
    logic                    r_valid5;
    t_ctrl                   r_ctrl5;
    logic [Q_W-1:0]          r_q;

    // Output stage.
    logic                    r_done;
    logic signed [OUT_W-1:0] r_result;
    logic                    r_bad_out;

    always_comb begin
        // Half an output LSB is added before the shift: ties go away from zero
        // because the sign is applied to the magnitude only afterwards.
        rnd    = Q_W'(1) << (r_ctrl4.sh - SH_W'(1));
        biased = Q_W'(r_prod) + rnd;

        sat      = (r_q > SAT_LIMIT);
        clipped  = sat ? SAT_LIMIT : r_q;
        mag_out  = OUT_W'(clipped);
        if (r_ctrl5.bad) begin
            n_result = '0;
        end else if (r_ctrl5.neg) begin
            n_result = -mag_out;
        end else begin
            n_result = mag_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_valid4 <= i_ctrl.valid;
            r_valid5 <= r_valid4;
            r_done   <= r_valid5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl4   <= i_ctrl;
        r_prod    <= i_mx * i_my;
        r_ctrl5   <= r_ctrl4;
        r_q       <= biased >> r_ctrl4.sh;
        r_result  <= n_result;
        r_bad_out <= r_ctrl5.bad;
    end

    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_bad_index    = r_bad_out;

endmodule

/* src/quad9_shape_function_eval.sv */
// Requests pass decode, multiply, magnitude, product, round and output stages.
// Throughput: one request per cycle; busy is held low, since every stage
// advances on each clock and the result strobe cannot be held off.
// The factor and product multipliers set the depth of each stage.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data registers
// are not reset.
`timescale 1ns / 1ps
`include "quad9_shape_function_eval_defines.svh"

module quad9_shape_function_eval (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_action,
    input  logic [3:0]                        i_node,
    input  logic signed [qsf_pkg::IN_W-1:0]   i_xi,
    input  logic signed [qsf_pkg::IN_W-1:0]   i_eta,
    output logic                              o_done,
    output logic signed [qsf_pkg::OUT_W-1:0]  o_result_value,
    output logic                              o_bad_index
);
    import qsf_pkg::*;

    t_ctrl            dec_ctrl;
    t_axis            dec_ax;
    t_axis            dec_ay;
    t_ctrl            fac_ctrl;
    logic [MAG_W-1:0] fac_mx;
    logic [MAG_W-1:0] fac_my;

    assign busy = 1'b0;

    qsf_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_action (i_action),
        .i_node   (i_node),
        .i_xi     (i_xi),
        .i_eta    (i_eta),
        .o_ctrl   (dec_ctrl),
        .o_ax     (dec_ax),
        .o_ay     (dec_ay)
    );

    qsf_factor u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dec_ctrl),
        .i_ax    (dec_ax),
        .i_ay    (dec_ay),
        .o_ctrl  (fac_ctrl),
        .o_mx    (fac_mx),
        .o_my    (fac_my)
    );

    qsf_round u_round (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (fac_ctrl),
        .i_mx           (fac_mx),
        .i_my           (fac_my),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_bad_index    (o_bad_index)
    );

    `QSF_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##6 o_done, "request lost in pipeline")
    `QSF_ASSERT(a_no_phantom, i_clk, i_rst_n, o_done |-> $past(start, 6), "result without request")
    `QSF_ASSERT(a_bad_flag, i_clk, i_rst_n, o_done |-> (o_bad_index == $past((i_action == ACT_INVALID) || (i_node > NODE_MAX), 6)), "error flag does not match request")
    `QSF_ASSERT_ALWAYS(a_bad_zero, i_clk, (o_done && o_bad_index) |-> (o_result_value == '0), "error result not zero")
    `QSF_ASSERT_ALWAYS(a_range, i_clk, o_done |-> ((o_result_value <= $signed(OUT_W'(SAT_LIMIT))) && (o_result_value >= -$signed(OUT_W'(SAT_LIMIT)))), "result outside saturation range")

endmodule

/* tb/sv/quad9_shape_check.sv */
`timescale 1ns / 1ps

module quad9_shape_check (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic [1:0]                            i_action,
    input  logic [3:0]                            i_node,
    input  logic signed [qsf_pkg::IN_W-1:0]       i_xi,
    input  logic signed [qsf_pkg::IN_W-1:0]       i_eta,
    input  logic                                  i_done,
    input  logic signed [qsf_pkg::OUT_W-1:0]      i_result_value,
    input  logic                                  i_bad_index,
    output int                                    o_outstanding,
    output int                                    o_fail_count
);

    import qsf_pkg::*;

    typedef enum logic [1:0] {
        FK_MINUS,
        FK_PLUS,
        FK_CENTER
    } factor_kind_e;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    bad;
    } shape_term_t;

    shape_term_t shape_terms_due[$];
    shape_term_t want_term;
    int          results_seen = 0;

    initial begin
        o_outstanding = 0;
        o_fail_count  = 0;
    end

    // One-dimensional factor at scale 2^(2*FRAC_BITS): x(x-1), x(x+1) or x^2-1.
    function automatic longint poly_factor(factor_kind_e kind, longint a);
        longint s;
        s = longint'(1) << FRAC_BITS;
        case (kind)
            FK_MINUS: return a * (a - s);
            FK_PLUS:  return a * (a + s);
            default:  return a * a - s * s;
        endcase
    endfunction

    // Its derivative at scale 2^FRAC_BITS: 2x-1, 2x+1 or 2x.
    function automatic longint slope_factor(factor_kind_e kind, longint a);
        longint s;
        s = longint'(1) << FRAC_BITS;
        case (kind)
            FK_MINUS: return 2 * a - s;
            FK_PLUS:  return 2 * a + s;
            default:  return 2 * a;
        endcase
    endfunction

    function automatic shape_term_t predict_shape_term(t_action act, logic [3:0] nd,
                                                       logic signed [IN_W-1:0] x,
                                                       logic signed [IN_W-1:0] y);
        shape_term_t  term;
        factor_kind_e kx;
        factor_kind_e ky;
        int           exp2;
        int           sh;
        logic         neg;
        longint       fx;
        longint       fy;
        logic [127:0] prod;
        logic [127:0] rnd;

        term.value = '0;
        term.bad   = 1'b1;
        if (act == ACT_INVALID || nd > NODE_MAX) begin
            return term;
        end
        term.bad = 1'b0;
        // The coefficient is 2^exp2 / 4, negated on the edge mid-side nodes.
        exp2 = 0;
        neg  = 1'b0;
        case (nd)
            4'd0: begin kx = FK_MINUS;  ky = FK_MINUS;  end
            4'd1: begin kx = FK_CENTER; ky = FK_MINUS;  exp2 = 1; neg = 1'b1; end
            4'd2: begin kx = FK_PLUS;   ky = FK_MINUS;  end
            4'd3: begin kx = FK_PLUS;   ky = FK_CENTER; exp2 = 1; neg = 1'b1; end
            4'd4: begin kx = FK_PLUS;   ky = FK_PLUS;   end
            4'd5: begin kx = FK_CENTER; ky = FK_PLUS;   exp2 = 1; neg = 1'b1; end
            4'd6: begin kx = FK_MINUS;  ky = FK_PLUS;   end
            4'd7: begin kx = FK_MINUS;  ky = FK_CENTER; exp2 = 1; neg = 1'b1; end
            default: begin kx = FK_CENTER; ky = FK_CENTER; exp2 = 2; end
        endcase
        case (act)
            ACT_VALUE: begin
                fx = poly_factor(kx, longint'(x));
                fy = poly_factor(ky, longint'(y));
                sh = SH_VAL - exp2;
            end
            ACT_DXI: begin
                fx = slope_factor(kx, longint'(x));
                fy = poly_factor(ky, longint'(y));
                sh = SH_DER - exp2;
            end
            default: begin
                fx = poly_factor(kx, longint'(x));
                fy = slope_factor(ky, longint'(y));
                sh = SH_DER - exp2;
            end
        endcase
        if (fx < 0) begin
            neg = !neg;
            fx  = -fx;
        end
        if (fy < 0) begin
            neg = !neg;
            fy  = -fy;
        end
        // Exact magnitude product, rounded once with ties away from zero.
        prod = 128'(fx) * 128'(fy);
        rnd  = (prod + (128'(1) << (sh - 1))) >> sh;
        if (rnd > 128'(SAT_LIMIT)) begin
            rnd = 128'(SAT_LIMIT);
        end
        term.value = OUT_W'(neg ? (128'(0) - rnd) : rnd);
        return term;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Results are compared before the request of this edge is queued.
            if (i_done) begin
                if (shape_terms_due.size() == 0) begin
                    report_mismatch("result strobe with no request outstanding",
                                    longint'(i_result_value), 0);
                end else begin
                    want_term = shape_terms_due.pop_front();
                    if (i_result_value !== want_term.value) begin
                        report_mismatch("result_value", longint'(i_result_value),
                                        longint'(want_term.value));
                    end
                    if (i_bad_index !== want_term.bad) begin
                        report_mismatch("bad_index", longint'(i_bad_index),
                                        longint'(want_term.bad));
                    end
                end
                results_seen = results_seen + 1;
            end
            if (i_start && !i_busy) begin
                shape_terms_due.push_back(predict_shape_term(t_action'(i_action), i_node,
                                                             i_xi, i_eta));
            end
            o_outstanding = shape_terms_due.size();
        end
    end

endmodule

/* tb/sv/tb_quad9_shape_function_eval.sv */
`timescale 1ns / 1ps

module tb_quad9_shape_function_eval;

    import qsf_pkg::*;

    localparam int  RANDOM_REQUESTS = 1550;
    localparam int  CYCLE_LIMIT     = 200000;
    localparam int  DRAIN_CYCLES    = 20;
    localparam logic signed [IN_W-1:0] ONE_Q  = IN_W'(1) << FRAC_BITS;
    localparam logic signed [IN_W-1:0] HALF_Q = IN_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [IN_W-1:0] MAX_IN = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] MIN_IN = {1'b1, {(IN_W-1){1'b0}}};

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     start     = 1'b0;
    logic [1:0]               i_action  = ACT_VALUE;
    logic [3:0]               i_node    = 4'd0;
    logic signed [IN_W-1:0]   i_xi      = '0;
    logic signed [IN_W-1:0]   i_eta     = '0;
    logic                     busy;
    logic                     o_done;
    logic signed [OUT_W-1:0]  o_result_value;
    logic                     o_bad_index;
    int                       outstanding;
    int                       fail_count;
    int                       cycle_count = 0;
    int                       idle_mode;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests outstanding",
                     cycle_count, outstanding);
            $display("tb_quad9_shape_function_eval: FAIL");
            $finish;
        end
    end

    quad9_shape_function_eval u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_node         (i_node),
        .i_xi           (i_xi),
        .i_eta          (i_eta),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_bad_index    (o_bad_index)
    );

    quad9_shape_check u_shape_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_node         (i_node),
        .i_xi           (i_xi),
        .i_eta          (i_eta),
        .i_done         (o_done),
        .i_result_value (o_result_value),
        .i_bad_index    (o_bad_index),
        .o_outstanding  (outstanding),
        .o_fail_count   (fail_count)
    );

    // Called at a falling edge; returns at a falling edge after the idle gap.
    task automatic send_request(t_action act, logic [3:0] nd,
                                logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                                int gap);
        start    <= 1'b1;
        i_action <= act;
        i_node   <= nd;
        i_xi     <= x;
        i_eta    <= y;
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
    endtask

    function automatic logic signed [IN_W-1:0] pick_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 4))
                0: return -ONE_Q;
                1: return -HALF_Q;
                2: return '0;
                3: return HALF_Q;
                default: return ONE_Q;
            endcase
        end else if (pick < 20) begin
            // Anywhere in the word, so that every bit toggles and saturation is hit.
            return IN_W'($urandom());
        end
        return IN_W'(int'($urandom_range(0, 2 * int'(ONE_Q))) - int'(ONE_Q));
    endfunction

    function automatic int pick_gap();
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 10);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
        endcase
    endfunction

    initial begin
        t_action     act;
        logic [3:0]  nd;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Node points, corners and centre, then the out-of-range inputs.
        send_request(ACT_VALUE, 4'd0, -ONE_Q, -ONE_Q, 0);
        send_request(ACT_VALUE, 4'd8, '0, '0, 0);
        send_request(ACT_VALUE, 4'd4, ONE_Q, ONE_Q, 1);
        send_request(ACT_VALUE, 4'd8, ONE_Q, ONE_Q, 0);
        send_request(ACT_VALUE, 4'd7, -ONE_Q, '0, 2);
        send_request(ACT_DXI, 4'd1, '0, -ONE_Q, 0);
        send_request(ACT_DXI, 4'd2, ONE_Q, -ONE_Q, 0);
        send_request(ACT_DXI, 4'd5, HALF_Q, ONE_Q, 3);
        send_request(ACT_DETA, 4'd3, ONE_Q, '0, 0);
        send_request(ACT_DETA, 4'd6, -ONE_Q, ONE_Q, 0);
        send_request(ACT_DETA, 4'd7, -ONE_Q, -HALF_Q, 1);
        // Coordinates far outside the element drive the result into saturation.
        send_request(ACT_VALUE, 4'd0, MIN_IN, MIN_IN, 0);
        send_request(ACT_VALUE, 4'd8, MIN_IN, '0, 0);
        send_request(ACT_DXI, 4'd4, MAX_IN, MAX_IN, 0);
        send_request(ACT_DETA, 4'd8, MIN_IN, MAX_IN, 0);
        send_request(ACT_DXI, 4'd0, MIN_IN, MAX_IN, 0);
        // Invalid node numbers and the unused action code.
        send_request(ACT_VALUE, 4'd9, ONE_Q, ONE_Q, 0);
        send_request(ACT_DETA, 4'd15, MAX_IN, MIN_IN, 0);
        send_request(ACT_INVALID, 4'd0, '0, '0, 0);
        send_request(ACT_INVALID, 4'd15, MIN_IN, MAX_IN, 4);
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) begin
                idle_mode = $urandom_range(0, 2);
            end
            if (n == RANDOM_REQUESTS / 2) begin
                wait_drained();
            end
            if ($urandom_range(0, 99) < 95) begin
                act = t_action'($urandom_range(0, 2));
            end else begin
                act = ACT_INVALID;
            end
            if ($urandom_range(0, 99) < 90) begin
                nd = 4'($urandom_range(0, 8));
            end else begin
                nd = 4'($urandom_range(9, 15));
            end
            send_request(act, nd, pick_coord(), pick_coord(), pick_gap());
        end

        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb_quad9_shape_function_eval: PASS");
        end else begin
            $display("tb_quad9_shape_function_eval: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/qsf_pkg.sv
src/qsf_decode.sv
src/qsf_factor.sv
src/qsf_round.sv
src/quad9_shape_function_eval.sv
tb/sv/quad9_shape_check.sv
tb/sv/tb_quad9_shape_function_eval.sv
